>>> hdl/lfu_pkg.sv
// Shared types and constants for the Lorentz factor unit.
// No dependencies; used by every module in hdl/.
package lfu_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INFINITE = 2'd1;
  localparam logic [1:0] STATUS_ABOVE    = 2'd2;

  localparam logic [31:0] FACTOR_MAX = 32'hFFFF_FFFF;

  localparam int unsigned QW64 = 64;

  // Outcome decided at entry, carried alongside the arithmetic.
  typedef struct packed {
    logic       forced;
    logic       force_one;
    logic [1:0] status;
  } side_t;

endpackage

>>> hdl/lorentz_factor_unit.sv
// Lorentz factor unit: top level with entry stage, divider and root pipelines, output register.
// Depends on lfu_pkg, lfu_div and lfu_sqrt.
//
//   channel  | direction | handshake                | payload
//   in       | sink      | in_valid_i / in_stall_o  | mode_i, sq_velocity_i
//   out      | source    | out_valid_o / out_stall_i| factor_o, status_o
//   cfg      | APB slave | psel, penable, pready    | paddr, pwdata, prdata
//
// One transaction enters per cycle unless the output stalls; it passes the entry register,
// one divider stage per quotient bit, one root stage per root bit and the output register.
// Reset clears all valid bits and sets c2_q to 2^30.
// A stalled output freezes the whole pipeline; in_stall_o is high exactly then.
module lorentz_factor_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] sq_velocity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] factor_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned QW = 32 + 2 * FRAC_BITS;
  localparam logic [31:0] FactorOne = 32'(64'd1 << FRAC_BITS);

  logic [31:0] c2_q;
  logic        en;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= 32'h4000_0000;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      c2_q <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? c2_q : '0;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Entry stage: special cases and denominator
  logic           e_valid_q;
  logic [32:0]    e_den_q;
  logic [31:0]    e_num_q;
  lfu_pkg::side_t e_side_q;
  logic [32:0]    den_d;
  lfu_pkg::side_t side_d;

  always_comb begin
    side_d = '0;
    side_d.status = lfu_pkg::STATUS_OK;
    if (!mode_i) begin
      den_d = {1'b0, c2_q} - {1'b0, sq_velocity_i};
      if (sq_velocity_i == c2_q) begin
        side_d.forced = 1'b1;
        side_d.status = lfu_pkg::STATUS_INFINITE;
      end else if (sq_velocity_i > c2_q) begin
        side_d.forced = 1'b1;
        side_d.status = lfu_pkg::STATUS_ABOVE;
      end
    end else begin
      den_d = {1'b0, c2_q} + {1'b0, sq_velocity_i};
      if (den_d == '0) begin
        side_d.forced    = 1'b1;
        side_d.force_one = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_den_q  <= den_d;
      e_num_q  <= c2_q;
      e_side_q <= side_d;
    end
  end

  logic           d_valid;
  logic [QW-1:0]  d_quo;
  lfu_pkg::side_t d_side;

  lfu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .num_i   (e_num_q),
    .den_i   (e_den_q),
    .side_i  (e_side_q),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  logic [63:0] rad;
  logic        over;

  if (QW > lfu_pkg::QW64) begin : g_wide
    assign rad  = d_quo[63:0];
    assign over = |d_quo[QW-1:64];
  end else begin : g_narrow
    assign rad  = 64'(d_quo);
    assign over = 1'b0;
  end

  logic           s_valid;
  logic [31:0]    s_root;
  logic           s_over;
  lfu_pkg::side_t s_side;

  lfu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .rad_i   (rad),
    .over_i  (over),
    .side_i  (d_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .over_o  (s_over),
    .side_o  (s_side)
  );

  // Output register
  logic        out_valid_q;
  logic [31:0] factor_q;
  logic [1:0]  status_q;
  logic [31:0] factor_d;

  always_comb begin
    if (s_side.forced) begin
      factor_d = s_side.force_one ? FactorOne : lfu_pkg::FACTOR_MAX;
    end else if (s_over) begin
      factor_d = lfu_pkg::FACTOR_MAX;
    end else begin
      factor_d = s_root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      factor_q <= factor_d;
      status_q <= s_side.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = factor_q;
  assign status_o    = status_q;

endmodule

>>> hdl/lfu_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor((num << 2F) / den).
// Depends on lfu_pkg.
module lfu_div #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned Steps = 32 + 2 * FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         num_i,
  input  logic [32:0]         den_i,
  input  lfu_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [Steps-1:0]    quo_o,
  output lfu_pkg::side_t      side_o
);

  logic                valid_q [0:Steps];
  logic [32:0]         rem_q   [0:Steps];
  logic [31:0]         num_q   [0:Steps];
  logic [32:0]         den_q   [0:Steps];
  logic [Steps-1:0]    quo_q   [0:Steps];
  lfu_pkg::side_t      side_q  [0:Steps];

  always_comb begin
    valid_q[0] = valid_i;
    rem_q[0]   = '0;
    num_q[0]   = num_i;
    den_q[0]   = den_i;
    quo_q[0]   = '0;
    side_q[0]  = side_i;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [33:0] rem_sh;
    logic [33:0] diff;
    logic        ge;
    logic [32:0] rem_d;

    always_comb begin
      rem_sh = {rem_q[k], num_q[k][31]};
      diff   = rem_sh - {1'b0, den_q[k]};
      ge     = rem_sh >= {1'b0, den_q[k]};
      rem_d  = ge ? diff[32:0] : rem_sh[32:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        num_q[k+1]  <= {num_q[k][30:0], 1'b0};
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= {quo_q[k][Steps-2:0], ge};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign quo_o   = quo_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

>>> hdl/lfu_sqrt.sv
// Pipelined digit-by-digit integer square root of a 64-bit value, one root bit per stage.
// Depends on lfu_pkg.
module lfu_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [63:0]    rad_i,
  input  logic           over_i,
  input  lfu_pkg::side_t side_i,
  output logic           valid_o,
  output logic [31:0]    root_o,
  output logic           over_o,
  output lfu_pkg::side_t side_o
);

  localparam int unsigned Steps = 32;

  logic           valid_q [0:Steps];
  logic [32:0]    rem_q   [0:Steps];
  logic [63:0]    rad_q   [0:Steps];
  logic [31:0]    root_q  [0:Steps];
  logic           over_q  [0:Steps];
  lfu_pkg::side_t side_q  [0:Steps];

  always_comb begin
    valid_q[0] = valid_i;
    rem_q[0]   = '0;
    rad_q[0]   = rad_i;
    root_q[0]  = '0;
    over_q[0]  = over_i;
    side_q[0]  = side_i;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    always_comb begin
      rem_sh = {rem_q[k], rad_q[k][63:62]};
      trial  = {1'b0, root_q[k], 2'b01};
      diff   = rem_sh - trial;
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? diff[32:0] : rem_sh[32:0];
        rad_q[k+1]  <= {rad_q[k][61:0], 2'b00};
        root_q[k+1] <= {root_q[k][30:0], ge};
        over_q[k+1] <= over_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign root_o  = root_q[Steps];
  assign over_o  = over_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

>>> hdl/lfu_checker.sv
// Port-level checks for the Lorentz factor unit, bound to the top level.
// Depends on lfu_pkg and lorentz_factor_unit.
module lfu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] factor_o,
  input logic [1:0]  status_o
);

  // Flagged transactions always carry the saturated factor
  a_status_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != lfu_pkg::STATUS_OK) |-> factor_o == lfu_pkg::FACTOR_MAX)
    else $error("nonzero status without saturated factor");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == lfu_pkg::STATUS_OK) || (status_o == lfu_pkg::STATUS_INFINITE)
                    || (status_o == lfu_pkg::STATUS_ABOVE))
    else $error("undefined status code");

  // Input is held off only by a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(factor_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind lorentz_factor_unit lfu_checker u_lfu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .factor_o    (factor_o),
  .status_o    (status_o)
);
